// ===== hdl/flr_pkg.sv =====
// flr_pkg: shared types, codes and constants of the framed link receiver.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package flr_pkg;

  localparam int unsigned LEN_BITS  = 16;  // width of the payload counter
  localparam int unsigned QDEPTH    = 4;   // words held between front and back
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0 = 8'h00;
  localparam logic [7:0] CTRL_SEQ1 = 8'h40;
  localparam logic [7:0] RR_SEQ1   = 8'h05;
  localparam logic [7:0] RR_SEQ0   = 8'h85;
  localparam logic [7:0] REJ_SEQ1  = 8'h01;
  localparam logic [7:0] REJ_SEQ0  = 8'h81;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  // configuration register indexes
  localparam logic REG_EXP_ADDR = 1'b0;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_ESC_ERR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HCHK = 3'd3,
    PH_DATA = 3'd4,
    PH_ESC  = 3'd5
  } phase_e;

  // one received byte with its class
  typedef struct packed {
    logic [7:0] data;
    logic       is_flag;
    logic       is_esc;
  } tok_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [7:0]  reply;
    logic        seq;
    logic [15:0] length;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/flr_front.sv =====
// flr_front: classifies received bytes and queues them for the frame engine.
// Depends on flr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flr_front
  import flr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] byte_i,
  output logic            full_o,
  output logic            tok_vld_o,
  output tok_t            tok_o,
  input  wire logic       tok_pop_i
);

  tok_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 wr_en, rd_en;
  tok_t                 tok_in;

  assign tok_in.data    = byte_i;
  assign tok_in.is_flag = (byte_i == FLAG_BYTE);
  assign tok_in.is_esc  = (byte_i == ESC_BYTE);

  assign full_o    = (cnt_q == QCNT_BITS'(QDEPTH));
  assign tok_vld_o = (cnt_q != '0);
  assign tok_o     = mem_q[rd_ptr_q];
  assign wr_en     = push_i && !full_o;
  assign rd_en     = tok_pop_i && tok_vld_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= tok_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/flr_back.sv =====
// flr_back: frame engine; walks header, un-stuffs the body, checks the trailer
// and holds one result word for the consumer. Depends on flr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flr_back
  import flr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] exp_addr_i,
  input  wire logic       tok_vld_i,
  input  wire tok_t       tok_i,
  output logic            tok_pop_o,
  output logic            res_vld_o,
  output res_t            res_o,
  input  wire logic       pop_i
);

  phase_e              phase_q, phase_d;
  logic                seq_q;
  logic [7:0]          ctrl_q;
  logic [7:0]          pend_q;
  logic                pend_vld_q;
  logic [7:0]          xor_q;
  logic [LEN_BITS-1:0] cnt_q;
  logic                res_vld_q;
  res_t                res_q;

  logic                go;
  logic                emit;
  res_t                res_new;
  logic                body_take;
  logic [7:0]          body_byte;
  logic                hdr_clear;
  logic                ctrl_load;
  logic                trailer_ok;
  logic [31:0]         cnt_ext;
  logic [15:0]         len_sat;

  // a word is taken when the result register is free or drains this cycle
  assign go        = tok_vld_i && (!res_vld_q || pop_i);
  assign tok_pop_o = go;
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

  assign cnt_ext = 32'(cnt_q);
  assign len_sat = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];

  always_comb begin
    if (!pend_vld_q) begin
      trailer_ok = 1'b0;
    end else if (cnt_q == '0) begin
      trailer_ok = 1'b1;
    end else begin
      trailer_ok = (xor_q == pend_q);
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (go) begin
      unique case (phase_q)
        PH_ADDR: begin
          if (tok_i.data == exp_addr_i) phase_d = PH_CTRL;
          else if (tok_i.is_flag)       phase_d = PH_ADDR;
          else                          phase_d = PH_HUNT;
        end
        PH_CTRL: begin
          if (tok_i.data == CTRL_SEQ0 || tok_i.data == CTRL_SEQ1) phase_d = PH_HCHK;
          else if (tok_i.is_flag)                                   phase_d = PH_ADDR;
          else                                                      phase_d = PH_HUNT;
        end
        PH_HCHK: begin
          if (tok_i.data == (exp_addr_i ^ ctrl_q)) phase_d = PH_DATA;
          else                                      phase_d = PH_HUNT;
        end
        PH_DATA: begin
          if (tok_i.is_flag)     phase_d = PH_ADDR;
          else if (tok_i.is_esc) phase_d = PH_ESC;
          else                   phase_d = PH_DATA;
        end
        PH_ESC: begin
          if (tok_i.data == ESC_FLAG || tok_i.data == ESC_ESC) phase_d = PH_DATA;
          else if (tok_i.is_flag)                              phase_d = PH_ADDR;
          else                                                 phase_d = PH_HUNT;
        end
        default: begin
          phase_d = tok_i.is_flag ? PH_ADDR : PH_HUNT;
        end
      endcase
    end
  end

  // per-word actions and result
  always_comb begin
    emit      = 1'b0;
    res_new   = '0;
    body_take = 1'b0;
    body_byte = tok_i.data;
    hdr_clear = 1'b0;
    ctrl_load = 1'b0;
    unique case (phase_q)
      PH_CTRL: begin
        ctrl_load = (tok_i.data == CTRL_SEQ0 || tok_i.data == CTRL_SEQ1);
      end
      PH_HCHK: begin
        hdr_clear = (tok_i.data == (exp_addr_i ^ ctrl_q));
      end
      PH_DATA: begin
        if (tok_i.is_flag) begin
          emit           = 1'b1;
          res_new.kind   = trailer_ok ? KIND_ACCEPT : KIND_REJECT;
          res_new.seq    = seq_q;
          res_new.length = len_sat;
          if (trailer_ok) res_new.reply = seq_q ? RR_SEQ1 : RR_SEQ0;
          else            res_new.reply = seq_q ? REJ_SEQ1 : REJ_SEQ0;
        end else if (!tok_i.is_esc) begin
          body_take = 1'b1;
        end
      end
      PH_ESC: begin
        if (tok_i.data == ESC_FLAG) begin
          body_take = 1'b1;
          body_byte = FLAG_BYTE;
        end else if (tok_i.data == ESC_ESC) begin
          body_take = 1'b1;
          body_byte = ESC_BYTE;
        end else begin
          emit         = 1'b1;
          res_new.kind = KIND_ESC_ERR;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // body bytes go out one word late
    if (body_take && pend_vld_q) begin
      emit            = 1'b1;
      res_new.kind    = KIND_PAYLOAD;
      res_new.payload = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      seq_q      <= 1'b0;
      ctrl_q     <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      xor_q      <= '0;
      cnt_q      <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (go) begin
        res_vld_q <= emit;
        if (ctrl_load) begin
          ctrl_q <= tok_i.data;
          seq_q  <= (tok_i.data == CTRL_SEQ1);
        end
        if (hdr_clear) begin
          pend_q     <= '0;
          pend_vld_q <= 1'b0;
          xor_q      <= '0;
          cnt_q      <= '0;
        end
        if (body_take) begin
          if (pend_vld_q) begin
            xor_q <= xor_q ^ pend_q;
            if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
          end
          pend_q     <= body_byte;
          pend_vld_q <= 1'b1;
        end
      end else if (pop_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      res_q <= res_new;
    end
  end

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !pop_i) |-> !go)
    else $error("flr_back: result overwritten before pop");

  // the escape phase is only entered from an escape word in the body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && phase_d == PH_ESC) |-> (phase_q == PH_DATA && tok_i.is_esc))
    else $error("flr_back: escape phase entered without escape word");

  // only payload words carry a payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.kind != KIND_PAYLOAD) |-> (res_q.payload == 8'h00))
    else $error("flr_back: payload byte set on status word");
`endif

endmodule

`default_nettype wire

// ===== hdl/framed_link_receiver.sv =====
// framed_link_receiver: top level with the configuration port, front queue
// and frame engine. Depends on flr_pkg, flr_front and flr_back.
`timescale 1ns / 1ps
`default_nettype none

// Receives one raw serial byte per push and strips HDLC-like framing: opening
// flag 0x7E, the address held in expected_address (byte address 0, reset 0x03),
// control 0x00 or 0x40 and a header check byte. Body bytes are un-stuffed and
// popped as payload words one byte late; at the closing flag one status word
// reports accept or reject with the RR/REJ reply byte, sequence bit and length.
// A bad escape yields an error word and drops the frame. A byte can be pushed
// every cycle while full is low; a four-word queue after the byte classifier
// and a one-word result register let either side stall for a while. With no
// stall, the word a byte causes passes through the queue and then the result
// register on its way to the result ports.
module framed_link_receiver
  import flr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [7:0]       reply_control_o,
  output logic             sequence_bit_o,
  output logic [15:0]      frame_length_o
);

  logic [7:0] exp_addr_q;
  logic       reg_hit;
  logic       tok_vld;
  tok_t       tok;
  logic       tok_pop;
  logic       res_vld;
  res_t       res;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_EXP_ADDR);
  assign prdata  = reg_hit ? {24'h0, exp_addr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= ADDR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      exp_addr_q <= pwdata[7:0];
    end
  end

  flr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .byte_i    (rx_byte_i),
    .full_o    (full),
    .tok_vld_o (tok_vld),
    .tok_o     (tok),
    .tok_pop_i (tok_pop)
  );

  flr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exp_addr_i (exp_addr_q),
    .tok_vld_i  (tok_vld),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .res_vld_o  (res_vld),
    .res_o      (res),
    .pop_i      (pop)
  );

  assign empty           = !res_vld;
  assign out_kind_o      = res.kind;
  assign payload_byte_o  = res.payload;
  assign reply_control_o = res.reply;
  assign sequence_bit_o  = res.seq;
  assign frame_length_o  = res.length;

endmodule

`default_nettype wire

// ===== sim/tb_framed_link_receiver.sv =====
// tb_framed_link_receiver: self-checking testbench for the framed link receiver.
// Needs flr_pkg and framed_link_receiver. Byte-level decoder model, queue-style
// handshakes and an APB port are driven and checked against each result word.
`timescale 1ns / 1ps

module tb_framed_link_receiver;
  import flr_pkg::*;

  localparam int          LIMIT      = 400_000;  // cycles before giving up
  localparam int          SETTLE     = 20;       // pipeline flush after last word
  localparam int          PHASE_BYTES = 125;
  localparam logic [2:0]  EXP_ADDR_OFFSET = {REG_EXP_ADDR, 2'b00};
  localparam res_t        NO_RES = '{KIND_PAYLOAD, 8'h00, 8'h00, 1'b0, 16'h0000};

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;  // want holds a hand-written word
    res_t       want;
  } step_t;

  localparam int SCRIPT_LEN = 28;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  reply_control_o;
  logic        sequence_bit_o;
  logic [15:0] frame_length_o;

  framed_link_receiver i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .empty           (empty),
    .pop             (pop),
    .out_kind_o      (out_kind_o),
    .payload_byte_o  (payload_byte_o),
    .reply_control_o (reply_control_o),
    .sequence_bit_o  (sequence_bit_o),
    .frame_length_o  (frame_length_o)
  );

  always #1 clk_i = ~clk_i;

  // directed opening: empty frame, one-byte frame, stuffed frame with a bad
  // trailer, flags in place of address and control, bad escape into a flag,
  // then a wrong address
  step_t script [SCRIPT_LEN] = '{
    '{8'h7E, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h7E, 1'b1, '{KIND_REJECT, 8'h00, REJ_SEQ0, 1'b0, 16'd0}},
    '{8'h03, 1'b0, NO_RES},
    '{8'h40, 1'b0, NO_RES},
    '{8'h43, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'h7E, 1'b1, '{KIND_ACCEPT, 8'h00, RR_SEQ1, 1'b1, 16'd0}},
    '{8'h03, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h7D, 1'b0, NO_RES},
    '{8'h5E, 1'b0, NO_RES},
    '{8'h7D, 1'b0, NO_RES},
    '{8'h5D, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h7E, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h7D, 1'b0, NO_RES},
    '{8'h7E, 1'b1, '{KIND_ESC_ERR, 8'h00, 8'h00, 1'b0, 16'd0}},
    '{8'h05, 1'b0, NO_RES}
  };

  res_t expected_words [$];
  int   sender_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   bytes_sent = 0;
  int   frames_sent = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   kind_seen [4] = '{0, 0, 0, 0};
  logic [7:0] cur_addr = ADDR_RESET;

  // decoder state
  phase_e              mdl_phase = PH_HUNT;
  logic [7:0]          mdl_addr = ADDR_RESET;
  logic [7:0]          mdl_ctl = '0;
  logic                mdl_seq = 1'b0;
  logic [7:0]          mdl_pend = '0;
  logic                mdl_pend_v = 1'b0;
  logic [7:0]          mdl_xor = '0;
  logic [LEN_BITS-1:0] mdl_count = '0;

  task automatic report_bad(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // a body byte pushes out the one held back before it
  task automatic take_payload(input logic [7:0] b, output bit fired, output res_t r);
    r = NO_RES;
    fired = mdl_pend_v;
    if (mdl_pend_v) begin
      r.payload = mdl_pend;
      mdl_xor ^= mdl_pend;
      if (mdl_count != '1) mdl_count++;
    end
    mdl_pend = b;
    mdl_pend_v = 1'b1;
  endtask

  task automatic decode_byte(input logic [7:0] b, output bit fired, output res_t r);
    logic ok;
    fired = 1'b0;
    r = NO_RES;
    case (mdl_phase)
      PH_ADDR: begin
        if (b == mdl_addr) mdl_phase = PH_CTRL;
        else if (b == FLAG_BYTE) mdl_phase = PH_ADDR;
        else mdl_phase = PH_HUNT;
      end
      PH_CTRL: begin
        if (b == CTRL_SEQ0 || b == CTRL_SEQ1) begin
          mdl_ctl = b;
          mdl_seq = (b == CTRL_SEQ1);
          mdl_phase = PH_HCHK;
        end else if (b == FLAG_BYTE) begin
          mdl_phase = PH_ADDR;
        end else begin
          mdl_phase = PH_HUNT;
        end
      end
      PH_HCHK: begin
        if (b == (mdl_addr ^ mdl_ctl)) begin
          mdl_phase = PH_DATA;
          mdl_pend = '0;
          mdl_pend_v = 1'b0;
          mdl_xor = '0;
          mdl_count = '0;
        end else begin
          mdl_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (b == FLAG_BYTE) begin
          // a lone body byte is its own trailer and always passes
          ok = mdl_pend_v && (mdl_count == 0 || mdl_xor == mdl_pend);
          fired = 1'b1;
          r.kind = ok ? KIND_ACCEPT : KIND_REJECT;
          if (ok) r.reply = mdl_seq ? RR_SEQ1 : RR_SEQ0;
          else r.reply = mdl_seq ? REJ_SEQ1 : REJ_SEQ0;
          r.seq = mdl_seq;
          r.length = 16'(mdl_count);
          mdl_phase = PH_ADDR;
        end else if (b == ESC_BYTE) begin
          mdl_phase = PH_ESC;
        end else begin
          take_payload(b, fired, r);
        end
      end
      PH_ESC: begin
        if (b == ESC_FLAG) begin
          mdl_phase = PH_DATA;
          take_payload(FLAG_BYTE, fired, r);
        end else if (b == ESC_ESC) begin
          mdl_phase = PH_DATA;
          take_payload(ESC_BYTE, fired, r);
        end else begin
          fired = 1'b1;
          r.kind = KIND_ESC_ERR;
          mdl_phase = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
        end
      end
      default: mdl_phase = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit   fired;
    res_t r;
    push_byte(b);
    decode_byte(b, fired, r);
    if (fired) expected_words.push_back(r);
  endtask

  task automatic feed_body(input logic [7:0] v);
    if (v == FLAG_BYTE) begin
      feed(ESC_BYTE);
      feed(ESC_FLAG);
    end else if (v == ESC_BYTE) begin
      feed(ESC_BYTE);
      feed(ESC_ESC);
    end else begin
      feed(v);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    wait_drained();
    // bytes that make no word may still sit in the pipeline
    repeat (SETTLE) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EXP_ADDR_OFFSET;
    pwdata <= {24'($urandom), a};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_addr = a;
    mdl_addr = a;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== a)
      report_bad($sformatf("address readback exp %02h got %02h", a, prdata[7:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_frame(input int max_len);
    logic [7:0] body [$];
    logic [7:0] ctl;
    logic [7:0] sum;
    logic [7:0] v;
    int         n;
    int         bad_at;
    ctl = $urandom_range(1) ? CTRL_SEQ1 : CTRL_SEQ0;
    if ($urandom_range(99) < 4) ctl = 8'($urandom_range(255));
    feed(FLAG_BYTE);
    feed(($urandom_range(99) < 6) ? 8'($urandom_range(255)) : cur_addr);
    feed(ctl);
    feed(($urandom_range(99) < 5) ? 8'($urandom_range(255)) : (cur_addr ^ ctl));
    n = $urandom_range(max_len);
    sum = '0;
    repeat (n) begin
      case ($urandom_range(7))
        0:       v = FLAG_BYTE;
        1:       v = ESC_BYTE;
        default: v = 8'($urandom_range(255));
      endcase
      body.push_back(v);
      sum ^= v;
    end
    // trailer: mostly right, sometimes wrong, rarely missing
    if ($urandom_range(99) >= 5)
      body.push_back(($urandom_range(99) < 80) ? sum : 8'($urandom_range(255)));
    bad_at = ($urandom_range(99) < 4) ? $urandom_range(body.size()) : -1;
    for (int i = 0; i <= body.size(); i++) begin
      if (i == bad_at) begin
        feed(ESC_BYTE);
        feed($urandom_range(1) ? FLAG_BYTE : 8'($urandom_range(255)));
      end
      if (i < body.size()) feed_body(body[i]);
    end
    feed(FLAG_BYTE);
    if ($urandom_range(99) < 10)
      repeat ($urandom_range(1, 4)) feed(8'($urandom_range(255)));
    frames_sent++;
  endtask

  always @(posedge clk_i) begin : check_words
    res_t got;
    res_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.kind = kind_e'(out_kind_o);
        got.payload = payload_byte_o;
        got.reply = reply_control_o;
        got.seq = sequence_bit_o;
        got.length = frame_length_o;
        if (expected_words.size() == 0) begin
          report_bad($sformatf("word kind %0d with nothing expected", got.kind));
        end else begin
          want = expected_words.pop_front();
          kind_seen[want.kind]++;
          if (got.kind !== want.kind || got.payload !== want.payload ||
              got.reply !== want.reply || got.seq !== want.seq ||
              got.length !== want.length)
            report_bad($sformatf(
              "exp kind %0d pay %02h reply %02h seq %0b len %0d, got %0d %02h %02h %0b %0d",
              want.kind, want.payload, want.reply, want.seq, want.length,
              got.kind, got.payload, got.reply, got.seq, got.length));
        end
      end
      pop <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout with %0d words outstanding", expected_words.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    bit         fired;
    res_t       r;
    int         phase_start;
    bit         paused;
    logic [7:0] addr_list [4];
    int         idle_tab [4];
    int         stall_tab [4];
    addr_list = '{8'h00, 8'hFF, 8'h7E, 8'h00};
    idle_tab = '{0, 64, 0, 32};
    stall_tab = '{0, 0, 64, 32};
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      push_byte(script[i].rx);
      decode_byte(script[i].rx, fired, r);
      if (script[i].typed) expected_words.push_back(script[i].want);
      else if (fired) expected_words.push_back(r);
    end

    for (int p = 0; p < 4; p++) begin
      write_address((p == 3) ? 8'($urandom_range(255)) : addr_list[p]);
      sender_idle_pct = idle_tab[p];
      rcv_stall_pct = stall_tab[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_random_frame(($urandom_range(9) == 0) ? 40 : 10);
        if (p == 1 && !paused && bytes_sent - phase_start > PHASE_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("sent %0d bytes in %0d frames over four handshake mixes and five addresses",
             bytes_sent, frames_sent);
    $display("checked %0d payload, %0d accepted, %0d rejected, %0d escape errors; %0d bad",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_ACCEPT], kind_seen[KIND_REJECT],
             kind_seen[KIND_ESC_ERR], mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
